[rtl/mawt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the multicast ack window tracker.
// No dependencies.
package mawt_pkg;

  localparam int unsigned DEF_CLIENTS    = 16;
  localparam int unsigned DEF_WINDOW_MAX = 64;
  localparam int unsigned SLOT_N         = 16;
  localparam int unsigned MAP_W          = 64;
  localparam int unsigned DIV_NW         = 20;
  localparam int unsigned DIV_DW         = 22;

  localparam logic [21:0] RTT_CAP    = 22'd3000000;
  localparam logic [21:0] RTT_FLOOR  = 22'd100;
  localparam logic [19:0] LIM_NUM    = 20'd1000000;
  localparam logic [19:0] RECIP_NUM  = 20'd65536;
  localparam logic [24:0] RECIP10    = 25'd26843546;
  localparam int unsigned RECIP10_SH = 28;
  localparam logic [14:0] W_ONE      = 15'd256;
  localparam logic [14:0] W_TWO      = 15'd512;
  localparam logic [7:0]  DUP_SAT    = 8'd255;
  localparam logic [7:0]  DUP_LIMIT  = 8'd3;

  typedef enum logic [1:0] {
    ACT_JOIN,
    ACT_RESP,
    ACT_UPDATE,
    ACT_LEAVE
  } act_e;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_UNKNOWN,
    ST_STALE,
    ST_REFUSED
  } stat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SMOOTH,
    S_SCALE,
    S_LIMGO,
    S_LIMWAIT,
    S_COUNT,
    S_ADJ,
    S_SQRT,
    S_SQFIN,
    S_RECIPWAIT,
    S_WRITE,
    S_EMIT
  } st_e;

  typedef struct packed {
    act_e             action;
    logic [3:0]       client;
    logic             slot_ok;
    logic             admit;
    logic             stale;
    logic [15:0]      ack_seq;
    logic [15:0]      slow;
    logic             rtt_upd;
    logic [21:0]      rtt_s;
    logic [21:0]      resp_rtt;
    logic [MAP_W-1:0] miss;
  } item_t;

endpackage

[rtl/mawt_front.sv]
`timescale 1ns / 1ps
// Front end: classifies each incoming transaction and queues it for the back end.
// Depends on mawt_pkg.
module mawt_front #(
  parameter int unsigned CLIENTS    = mawt_pkg::DEF_CLIENTS,
  parameter int unsigned WINDOW_MAX = mawt_pkg::DEF_WINDOW_MAX
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action_i,
  input  logic [3:0]          client_index_i,
  input  logic                admit_i,
  input  logic [15:0]         ack_seq_i,
  input  logic [15:0]         reported_max_seq_i,
  input  logic [15:0]         server_low_seq_i,
  input  logic [15:0]         server_max_seq_i,
  input  logic                rtt_valid_i,
  input  logic signed [31:0]  rtt_sample_i,
  input  logic [6:0]          bitmap_bits_i,
  input  logic [63:0]         received_map_i,
  output logic                item_valid_o,
  output mawt_pkg::item_t     item_o,
  input  logic                pop_i
);
  import mawt_pkg::*;

  localparam int unsigned QD = 2;

  item_t       cls;
  logic [31:0] smp;
  logic [15:0] stale_d, cnt_d, brk_d, gap_d;
  logic [16:0] nc, brk, n17;
  logic [6:0]  n, bits;
  logic [21:0] clamp_s;

  item_t       q_mem [QD];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  always_comb begin
    smp     = $unsigned(rtt_sample_i);
    stale_d = ack_seq_i - server_low_seq_i;
    cnt_d   = reported_max_seq_i - ack_seq_i;
    brk_d   = ack_seq_i - server_max_seq_i;
    gap_d   = server_max_seq_i - ack_seq_i;
    nc      = cnt_d[15] ? 17'd0 :
              (({1'b0, cnt_d} > 17'(WINDOW_MAX)) ? 17'(WINDOW_MAX) : {1'b0, cnt_d});
    brk     = brk_d[15] ? {1'b0, gap_d} : 17'd0;
    n17     = (nc < brk) ? nc : brk;
    n       = n17[6:0];
    bits    = (bitmap_bits_i > 7'd64) ? 7'd64 : bitmap_bits_i;

    if (smp < 32'(RTT_FLOOR)) begin
      clamp_s = RTT_FLOOR;
    end else if (smp > 32'(RTT_CAP)) begin
      clamp_s = RTT_CAP;
    end else begin
      clamp_s = smp[21:0];
    end

    cls          = '0;
    cls.action   = act_e'(action_i);
    cls.client   = client_index_i;
    cls.slot_ok  = ({5'd0, client_index_i} < 9'(CLIENTS));
    cls.admit    = admit_i;
    cls.stale    = stale_d[15];
    cls.ack_seq  = ack_seq_i;
    cls.slow     = server_low_seq_i;
    cls.rtt_upd  = rtt_valid_i && (smp != 32'd0) && !smp[31];
    cls.rtt_s    = clamp_s;
    if (smp[31]) begin
      cls.resp_rtt = '0;
    end else if (smp > 32'(RTT_CAP)) begin
      cls.resp_rtt = RTT_CAP;
    end else begin
      cls.resp_rtt = smp[21:0];
    end
    for (int i = 0; i < MAP_W; i++) begin
      cls.miss[i] = (7'(i) < n) && ((7'(i) >= bits) || !received_map_i[i]);
    end
  end

  assign busy         = (cnt_q == 2'(QD));
  assign push         = start && !busy;
  assign pop          = pop_i && (cnt_q != 2'd0);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/mawt_div.sv]
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on mawt_pkg.
module mawt_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mawt_pkg::DIV_NW-1:0] num_i,
  input  logic [mawt_pkg::DIV_DW-1:0] den_i,
  output logic                        done_o,
  output logic [mawt_pkg::DIV_NW-1:0] quot_o
);
  import mawt_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [CW-1:0]     cnt_q;
  logic              run_q, done_q;
  logic [DIV_DW:0]   remsh, diff;
  logic              qbit;

  always_comb begin
    remsh = {rem_q, quo_q[DIV_NW-1]};
    diff  = remsh - {1'b0, den_q};
    qbit  = (remsh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= qbit ? diff[DIV_DW-1:0] : remsh[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DIV_NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[rtl/mawt_back.sv]
`timescale 1ns / 1ps
// Back end: client table, RTT and window update sequencer, NAK result emission.
// Depends on mawt_pkg and mawt_div.
module mawt_back #(
  parameter int unsigned WINDOW_MAX = mawt_pkg::DEF_WINDOW_MAX
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  mawt_pkg::item_t item_i,
  output logic            pop_o,
  output logic            result_strobe_o,
  output logic [3:0]      out_client_o,
  output logic [1:0]      status_o,
  output logic            nak_valid_o,
  output logic [15:0]     nak_seq_o,
  output logic            last_o,
  output logic [14:0]     window_q8_o,
  output logic [15:0]     client_ack_o,
  output logic [21:0]     client_rtt_us_o
);
  import mawt_pkg::*;

  localparam logic [19:0] WCAP = 20'(WINDOW_MAX * 256);

  logic        tk_q    [SLOT_N];
  logic [15:0] tack_q  [SLOT_N];
  logic [15:0] twseq_q [SLOT_N];
  logic [14:0] twin_q  [SLOT_N];
  logic [7:0]  tdup_q  [SLOT_N];
  logic [21:0] trtt_q  [SLOT_N];

  st_e         st_q, st_d;
  item_t       it_q;
  logic        known_w_q, upd_q;
  logic [15:0] ack_w_q, wseq_w_q;
  logic [14:0] w_q;
  logic [7:0]  dup_q;
  logic [21:0] rtt_q;
  stat_e       status_q;
  logic [49:0] prod_q;
  logic [63:0] m_q, em_q, em_rest;
  logic [1:0]  k_q;
  logic [22:0] sv_q, bit_q;
  logic [23:0] root_q, sq_t, sq_sv;

  logic        known_now, adj_ok, lost_many, div_start;
  logic [15:0] dd, nws, nwd, adj_d;
  logic [24:0] smooth_x;
  logic [14:0] w_half, w2, wr;
  logic [19:0] div_num, div_quo, wsum;
  logic [21:0] div_den;
  logic        div_done;
  logic [5:0]  idx;

  mawt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quo)
  );

  always_comb begin
    known_now = it_q.slot_ok && tk_q[it_q.client];
    dd        = it_q.ack_seq - tack_q[it_q.client];
    smooth_x  = {rtt_q, 3'b000} + {3'b000, rtt_q} + {3'b000, it_q.rtt_s};
    adj_d     = ack_w_q - wseq_w_q;
    adj_ok    = !adj_d[15];
    lost_many = (m_q != 64'd0);
    w_half    = w_q >> 1;
    w2        = (w_half < W_TWO) ? W_TWO : w_half;
    nws       = ack_w_q + {9'd0, w2[14:8]};
    nwd       = nws - wseq_w_q;
    sq_t      = root_q + {1'b0, bit_q};
    sq_sv     = {1'b0, sv_q} - sq_t;
    wr        = (root_q > {9'd0, w_q}) ? 15'd0 : (w_q - root_q[14:0]);
    wsum      = {5'd0, w_q} + div_quo;
    em_rest   = em_q & (em_q - 64'd1);
    div_start = 1'b0;
    div_num   = LIM_NUM;
    div_den   = rtt_q;
    if (st_q == S_LIMGO) begin
      div_start = 1'b1;
    end else if ((st_q == S_ADJ) && adj_ok && (dup_q < DUP_LIMIT) && !lost_many &&
                 (w_q != 15'd0)) begin
      div_start = 1'b1;
      div_num   = RECIP_NUM;
      div_den   = {7'd0, w_q};
    end
    idx = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (em_q[i]) begin
        idx = 6'(i);
      end
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (item_valid_i) begin
          st_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (it_q.action == ACT_UPDATE && known_now && !it_q.stale) begin
          st_d = it_q.rtt_upd ? S_SMOOTH : S_COUNT;
        end else begin
          st_d = S_WRITE;
        end
      end
      S_SMOOTH:  st_d = S_SCALE;
      S_SCALE:   st_d = S_LIMGO;
      S_LIMGO:   st_d = S_LIMWAIT;
      S_LIMWAIT: begin
        if (div_done) begin
          st_d = S_COUNT;
        end
      end
      S_COUNT: begin
        if (k_q == 2'd2) begin
          st_d = S_ADJ;
        end
      end
      S_ADJ: begin
        if (!adj_ok || dup_q >= DUP_LIMIT) begin
          st_d = S_WRITE;
        end else if (lost_many) begin
          st_d = S_SQRT;
        end else if (w_q != 15'd0) begin
          st_d = S_RECIPWAIT;
        end else begin
          st_d = S_WRITE;
        end
      end
      S_SQRT: begin
        if (bit_q == 23'd1) begin
          st_d = S_SQFIN;
        end
      end
      S_SQFIN: st_d = S_WRITE;
      S_RECIPWAIT: begin
        if (div_done) begin
          st_d = S_WRITE;
        end
      end
      S_WRITE: st_d = S_EMIT;
      S_EMIT: begin
        if (em_rest == 64'd0) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o           = (st_q == S_IDLE);
    result_strobe_o = (st_q == S_EMIT);
    out_client_o    = it_q.client;
    status_o        = status_q;
    nak_valid_o     = (em_q != 64'd0);
    nak_seq_o       = nak_valid_o ? (it_q.ack_seq + {10'd0, idx}) : 16'd0;
    last_o          = (em_rest == 64'd0);
    window_q8_o     = known_w_q ? w_q : 15'd0;
    client_ack_o    = known_w_q ? ack_w_q : 16'd0;
    client_rtt_us_o = known_w_q ? rtt_q : 22'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      for (int i = 0; i < SLOT_N; i++) begin
        tk_q[i] <= 1'b0;
      end
    end else begin
      st_q <= st_d;
      if (st_q == S_WRITE) begin
        tk_q[it_q.client] <= known_w_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (item_valid_i) begin
          it_q <= item_i;
        end
      end
      S_LOAD: begin
        ack_w_q   <= tack_q[it_q.client];
        wseq_w_q  <= twseq_q[it_q.client];
        w_q       <= twin_q[it_q.client];
        dup_q     <= tdup_q[it_q.client];
        rtt_q     <= trtt_q[it_q.client];
        known_w_q <= known_now;
        status_q  <= ST_DONE;
        upd_q     <= 1'b0;
        m_q       <= it_q.miss;
        k_q       <= 2'd0;
        if (it_q.action == ACT_JOIN) begin
          if (!known_now && (!it_q.slot_ok || !it_q.admit)) begin
            status_q <= ST_REFUSED;
          end else begin
            known_w_q <= 1'b1;
            if (!known_now) begin
              w_q   <= '0;
              rtt_q <= '0;
              dup_q <= '0;
            end
            ack_w_q  <= it_q.slow;
            wseq_w_q <= it_q.slow;
          end
        end else if (!known_now) begin
          status_q <= ST_UNKNOWN;
        end else begin
          case (it_q.action)
            ACT_RESP: rtt_q <= it_q.resp_rtt;
            ACT_UPDATE: begin
              if (it_q.stale) begin
                status_q <= ST_STALE;
              end else begin
                upd_q <= 1'b1;
                if (dd == 16'd0) begin
                  if (tdup_q[it_q.client] < DUP_SAT) begin
                    dup_q <= tdup_q[it_q.client] + 8'd1;
                  end
                end else if (!dd[15]) begin
                  ack_w_q <= it_q.ack_seq;
                  dup_q   <= '0;
                end
              end
            end
            ACT_LEAVE: known_w_q <= 1'b0;
            default:   known_w_q <= known_now;
          endcase
        end
      end
      S_SMOOTH: prod_q <= 50'(smooth_x) * 50'(RECIP10);
      S_SCALE:  rtt_q  <= prod_q[RECIP10_SH +: 22];
      S_LIMWAIT: begin
        if (div_done && ({13'd0, w_q} > {div_quo, 8'd0})) begin
          w_q <= (w_half < W_ONE) ? W_ONE : w_half;
        end
      end
      S_COUNT: begin
        m_q <= m_q & (m_q - 64'd1);
        k_q <= k_q + 2'd1;
      end
      S_ADJ: begin
        if (adj_ok) begin
          if (dup_q >= DUP_LIMIT) begin
            w_q   <= w2;
            dup_q <= '0;
            if (!nwd[15] && nwd != 16'd0) begin
              wseq_w_q <= nws;
            end
          end else if (lost_many) begin
            sv_q   <= {w_q, 8'd0};
            root_q <= '0;
            bit_q  <= 23'h400000;
          end else if (w_q == 15'd0) begin
            w_q      <= W_ONE;
            wseq_w_q <= ack_w_q;
          end
        end
      end
      S_SQRT: begin
        if ({1'b0, sv_q} >= sq_t) begin
          sv_q   <= sq_sv[22:0];
          root_q <= (root_q >> 1) + {1'b0, bit_q};
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_SQFIN: begin
        w_q      <= (wr < W_TWO) ? W_TWO : wr;
        wseq_w_q <= ack_w_q;
        dup_q    <= '0;
      end
      S_RECIPWAIT: begin
        if (div_done) begin
          w_q      <= (wsum > WCAP) ? WCAP[14:0] : wsum[14:0];
          wseq_w_q <= ack_w_q;
        end
      end
      S_WRITE: begin
        tack_q[it_q.client]  <= ack_w_q;
        twseq_q[it_q.client] <= wseq_w_q;
        twin_q[it_q.client]  <= w_q;
        tdup_q[it_q.client]  <= dup_q;
        trtt_q[it_q.client]  <= rtt_q;
        em_q                 <= upd_q ? it_q.miss : 64'd0;
      end
      S_EMIT: em_q <= em_rest;
      default: em_q <= em_q;
    endcase
  end

endmodule

[rtl/multicast_ack_window_tracker_top.sv]
`timescale 1ns / 1ps
// Top level of the multicast ack window tracker.
// Depends on mawt_pkg, mawt_front, mawt_back (and mawt_div below it).
//
// Usage: a transaction is taken on a rising edge with start high and busy low;
// the action, client slot and packet fields are sampled on that edge. The front
// end classifies it and holds up to two transactions; busy is high only while
// both queue entries are full.
// Results appear on the result ports one per cycle, marked by result_strobe_o,
// and are taken at the edge ending that cycle; the receiver cannot stall them.
// An ack update gives one result per missing sequence (at least one result),
// last_o marking the final one; other actions give exactly one result.
// Join, join response, leave and refused or stale transactions go from the
// load state straight to the table write and then emit their result. An ack
// update reaches its first result after up to two passes of the shared
// divider (or one pass and a square root), then gives its further NAK
// results one per cycle. The back end processes one transaction at a time;
// that sets throughput.
// Reset clears the known-client flags and the queue; other table fields are
// written by a join before they are read.
module multicast_ack_window_tracker_top #(
  parameter int unsigned CLIENTS    = mawt_pkg::DEF_CLIENTS,
  parameter int unsigned WINDOW_MAX = mawt_pkg::DEF_WINDOW_MAX
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [3:0]         client_index_i,
  input  logic               admit_i,
  input  logic [15:0]        ack_seq_i,
  input  logic [15:0]        reported_max_seq_i,
  input  logic [15:0]        server_low_seq_i,
  input  logic [15:0]        server_max_seq_i,
  input  logic               rtt_valid_i,
  input  logic signed [31:0] rtt_sample_i,
  input  logic [6:0]         bitmap_bits_i,
  input  logic [63:0]        received_map_i,
  output logic               result_strobe_o,
  output logic [3:0]         out_client_o,
  output logic [1:0]         status_o,
  output logic               nak_valid_o,
  output logic [15:0]        nak_seq_o,
  output logic               last_o,
  output logic [14:0]        window_q8_o,
  output logic [15:0]        client_ack_o,
  output logic [21:0]        client_rtt_us_o
);
  import mawt_pkg::*;

  item_t item;
  logic  item_valid, pop;

  mawt_front #(
    .CLIENTS    (CLIENTS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .client_index_i     (client_index_i),
    .admit_i            (admit_i),
    .ack_seq_i          (ack_seq_i),
    .reported_max_seq_i (reported_max_seq_i),
    .server_low_seq_i   (server_low_seq_i),
    .server_max_seq_i   (server_max_seq_i),
    .rtt_valid_i        (rtt_valid_i),
    .rtt_sample_i       (rtt_sample_i),
    .bitmap_bits_i      (bitmap_bits_i),
    .received_map_i     (received_map_i),
    .item_valid_o       (item_valid),
    .item_o             (item),
    .pop_i              (pop)
  );

  mawt_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .pop_o           (pop),
    .result_strobe_o (result_strobe_o),
    .out_client_o    (out_client_o),
    .status_o        (status_o),
    .nak_valid_o     (nak_valid_o),
    .nak_seq_o       (nak_seq_o),
    .last_o          (last_o),
    .window_q8_o     (window_q8_o),
    .client_ack_o    (client_ack_o),
    .client_rtt_us_o (client_rtt_us_o)
  );

`ifndef NO_ASSERTIONS
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |=> !result_strobe_o)
    else $error("result strobe directly after final result");

  a_plain_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !nak_valid_o |-> last_o)
    else $error("result without NAK is not the final one");

  a_nak_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o != ST_DONE) |-> !nak_valid_o)
    else $error("NAK reported with error status");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multicast_ack_window_tracker_top.
// Directed and random receiver packets are checked against a cycle-free table model.
// Depends on mawt_pkg and the RTL under rtl/.
module tb_top;
  import mawt_pkg::*;

  localparam int unsigned WMAX_Q8 = 64 * 256;

  typedef struct {
    act_e        action;
    bit [3:0]    client;
    bit          admit;
    bit [15:0]   ack;
    bit [15:0]   rmax;
    bit [15:0]   slow;
    bit [15:0]   smax;
    bit          rv;
    bit [31:0]   sample;
    bit [6:0]    bits;
    bit [63:0]   map;
  } pkt_t;

  typedef struct {
    bit [3:0]  client;
    stat_e     status;
    bit        nak_valid;
    bit [15:0] nak_seq;
    bit        last;
    bit [14:0] win;
    bit [15:0] ack;
    bit [21:0] rtt;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = '0;
  logic [3:0] client_index_i = '0;
  logic admit_i = 1'b0;
  logic [15:0] ack_seq_i = '0, reported_max_seq_i = '0, server_low_seq_i = '0;
  logic [15:0] server_max_seq_i = '0;
  logic rtt_valid_i = 1'b0;
  logic signed [31:0] rtt_sample_i = '0;
  logic [6:0] bitmap_bits_i = '0;
  logic [63:0] received_map_i = '0;
  logic result_strobe_o, nak_valid_o, last_o;
  logic [3:0] out_client_o;
  logic [1:0] status_o;
  logic [15:0] nak_seq_o, client_ack_o;
  logic [14:0] window_q8_o;
  logic [21:0] client_rtt_us_o;

  // table model
  bit        t_known [16];
  bit [15:0] t_ack [16];
  bit [15:0] t_wseq [16];
  bit [14:0] t_win [16];
  bit [7:0]  t_dup [16];
  bit [21:0] t_rtt [16];

  res_t expected_q[$];
  int   errors = 0;

  multicast_ack_window_tracker_top dut (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

  function automatic int sdiff(bit [15:0] a, bit [15:0] b);
    bit signed [15:0] d;
    d = a - b;
    return int'(d);
  endfunction

  function automatic bit [31:0] isqrt(bit [31:0] v);
    bit [31:0] root, b;
    root = 0;
    b = 32'h4000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else root >>= 1;
      b >>= 2;
    end
    return root;
  endfunction

  task automatic predict_results(pkt_t p);
    bit [3:0] c;
    stat_e st;
    bit [15:0] naks[64];
    int nn, cnt, bits, total;
    bit [31:0] w, s, lim, lost, r, nws;
    bit [15:0] sq;
    res_t e;
    c = p.client;
    st = ST_DONE;
    nn = 0;
    case (p.action)
      ACT_JOIN: begin
        if (!t_known[c] && !p.admit) st = ST_REFUSED;
        else begin
          if (!t_known[c]) begin
            t_known[c] = 1;
            t_win[c] = 0;
            t_rtt[c] = 0;
            t_dup[c] = 0;
          end
          t_ack[c] = p.slow;
          t_wseq[c] = p.slow;
        end
      end
      default: begin
        if (!t_known[c]) st = ST_UNKNOWN;
        else if (p.action == ACT_RESP) begin
          s = p.sample;
          if (s[31]) s = 0;
          else if (s > RTT_CAP) s = RTT_CAP;
          t_rtt[c] = s[21:0];
        end else if (p.action == ACT_LEAVE) t_known[c] = 0;
        else if (sdiff(p.ack, p.slow) < 0) st = ST_STALE;
        else begin
          w = {17'd0, t_win[c]};
          lost = 0;
          if (p.ack == t_ack[c]) begin
            if (t_dup[c] < DUP_SAT) t_dup[c]++;
          end else if (sdiff(p.ack, t_ack[c]) > 0) begin
            t_ack[c] = p.ack;
            t_dup[c] = 0;
          end
          if (p.rv && p.sample != 0 && !p.sample[31]) begin
            s = p.sample < RTT_FLOOR ? RTT_FLOOR : p.sample;
            if (s > RTT_CAP) s = RTT_CAP;
            t_rtt[c] = 22'((9 * t_rtt[c] + s) / 10);
            lim = 1000000 / t_rtt[c];
            if (w > (lim << 8)) begin
              w >>= 1;
              if (w < 256) w = 256;
            end
          end
          bits = p.bits > 64 ? 64 : int'(p.bits);
          cnt = sdiff(p.rmax, p.ack);
          if (cnt > 64) cnt = 64;
          for (int i = 0; i < cnt; i++) begin
            sq = 16'(p.ack + i);
            if (sdiff(sq, p.smax) >= 0) break;
            if (i >= bits || !p.map[i]) begin
              naks[nn++] = sq;
              lost++;
            end
          end
          if (sdiff(t_ack[c], t_wseq[c]) >= 0) begin
            if (t_dup[c] >= DUP_LIMIT) begin
              w >>= 1;
              if (w < 512) w = 512;
              t_dup[c] = 0;
              nws = t_ack[c] + (w >> 8);
              if (sdiff(nws[15:0], t_wseq[c]) > 0) t_wseq[c] = nws[15:0];
            end else if (lost > 3) begin
              r = isqrt(w << 8);
              w = r > w ? 0 : w - r;
              if (w < 512) w = 512;
              t_wseq[c] = t_ack[c];
              t_dup[c] = 0;
            end else if (w > 0) begin
              w += 65536 / w;
              if (w > WMAX_Q8) w = WMAX_Q8;
              t_wseq[c] = t_ack[c];
            end else begin
              w = 256;
              t_wseq[c] = t_ack[c];
            end
          end
          t_win[c] = w[14:0];
        end
      end
    endcase
    total = nn > 0 ? nn : 1;
    for (int k = 0; k < total; k++) begin
      e.client = c;
      e.status = st;
      e.nak_valid = nn > 0;
      e.nak_seq = nn > 0 ? naks[k] : 16'd0;
      e.last = k == total - 1;
      e.win = t_known[c] ? t_win[c] : 15'd0;
      e.ack = t_known[c] ? t_ack[c] : 16'd0;
      e.rtt = t_known[c] ? t_rtt[c] : 22'd0;
      expected_q.push_back(e);
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && result_strobe_o) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result for client %0d", out_client_o);
      end else begin
        e = expected_q.pop_front();
        if (out_client_o !== e.client || status_o !== e.status ||
            nak_valid_o !== e.nak_valid || nak_seq_o !== e.nak_seq ||
            last_o !== e.last || window_q8_o !== e.win ||
            client_ack_o !== e.ack || client_rtt_us_o !== e.rtt) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp c%0d st%0d nv%0d nak%0d l%0d w%0d a%0d r%0d | act c%0d st%0d nv%0d nak%0d l%0d w%0d a%0d r%0d",
                     e.client, e.status, e.nak_valid, e.nak_seq, e.last, e.win,
                     e.ack, e.rtt, out_client_o, status_o, nak_valid_o, nak_seq_o,
                     last_o, window_q8_o, client_ack_o, client_rtt_us_o);
        end
      end
    end
  end

  // called at a rising edge; returns at the edge that took the transaction
  task automatic send_pkt(pkt_t p, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= p.action;
    client_index_i <= p.client;
    admit_i <= p.admit;
    ack_seq_i <= p.ack;
    reported_max_seq_i <= p.rmax;
    server_low_seq_i <= p.slow;
    server_max_seq_i <= p.smax;
    rtt_valid_i <= p.rv;
    rtt_sample_i <= p.sample;
    bitmap_bits_i <= p.bits;
    received_map_i <= p.map;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    predict_results(p);
    @(posedge clk_i);
  endtask

  function automatic pkt_t mk(act_e a, bit [3:0] c);
    pkt_t p;
    p = '{action: a, default: 0};
    p.client = c;
    p.admit = 1;
    return p;
  endfunction

  function automatic pkt_t mk_upd(bit [3:0] c, bit [15:0] ack, int span, bit [63:0] map);
    pkt_t p;
    p = mk(ACT_UPDATE, c);
    p.ack = ack;
    p.slow = ack;
    p.rmax = 16'(ack + span);
    p.smax = 16'(ack + span);
    p.bits = 64;
    p.map = map;
    return p;
  endfunction

  function automatic pkt_t rand_pkt();
    pkt_t p;
    bit [3:0] c;
    c = 4'($urandom_range(0, 9) < 7 ? $urandom_range(0, 3) : $urandom_range(0, 15));
    p = mk(ACT_UPDATE, c);
    p.admit = $urandom_range(0, 3) != 0;
    p.rv = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 3))
      0: p.sample = $urandom;
      1: p.sample = $urandom_range(0, 200);
      2: p.sample = $urandom_range(2900000, 3100000);
      default: p.sample = $urandom_range(1000, 200000);
    endcase
    p.bits = $urandom_range(0, 4) == 0 ? 7'($urandom_range(0, 127)) : 7'd64;
    p.map = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) p.map = p.map | {$urandom, $urandom} | {$urandom, $urandom};
    if ($urandom_range(0, 6) == 0) begin
      p.action = act_e'($urandom_range(0, 3));
      p.ack = 16'($urandom);
      p.rmax = 16'($urandom);
      p.slow = 16'($urandom);
      p.smax = 16'($urandom);
      p.bits = 7'($urandom_range(0, 127));
      return p;
    end
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        p.action = ACT_JOIN;
        p.slow = 16'($urandom);
      end
      3, 4: p.action = ACT_RESP;
      5: p.action = ACT_LEAVE;
      default: begin
        p.ack = $urandom_range(0, 2) == 0 ? t_ack[c] :
                16'(t_ack[c] + $urandom_range(0, 12));
        if ($urandom_range(0, 9) == 0) p.ack = 16'(t_ack[c] - $urandom_range(1, 5));
        p.slow = 16'(p.ack - $urandom_range(0, 6));
        if ($urandom_range(0, 14) == 0) p.slow = 16'(p.ack + $urandom_range(1, 5));
        p.rmax = 16'(p.ack + $urandom_range(0, 72) - ($urandom_range(0, 9) == 0 ? 20 : 0));
        p.smax = 16'(p.ack + $urandom_range(0, 80));
      end
    endcase
    return p;
  endfunction

  task automatic test_membership();
    pkt_t p;
    send_pkt(mk(ACT_UPDATE, 4'd5), 0);
    p = mk(ACT_JOIN, 4'd5);
    p.admit = 0;
    send_pkt(p, 1);
    p.admit = 1;
    p.slow = 16'hFFFF;
    send_pkt(p, 0);
    p.slow = 16'h0010;
    p.admit = 0;
    send_pkt(p, 2);
    send_pkt(mk(ACT_LEAVE, 4'd5), 0);
    send_pkt(mk(ACT_RESP, 4'd5), 3);
    send_pkt(mk(ACT_LEAVE, 4'd15), 0);
    p = mk(ACT_JOIN, 4'd15);
    send_pkt(p, 0);
  endtask

  task automatic test_rtt();
    pkt_t p;
    p = mk(ACT_RESP, 4'd15);
    p.sample = 32'h8000_0000;
    send_pkt(p, 0);
    p.sample = 32'h7FFF_FFFF;
    send_pkt(p, 1);
    p = mk_upd(4'd15, 16'd0, 0, '1);
    p.rv = 1;
    p.sample = 32'd3000000;
    send_pkt(p, 0);
    p.sample = 32'd5;
    send_pkt(p, 4);
    p.sample = 32'hFFFF_FFF0;
    send_pkt(p, 0);
  endtask

  task automatic test_window();
    pkt_t p;
    p = mk(ACT_JOIN, 4'd0);
    p.slow = 16'hFFF0;
    send_pkt(p, 0);
    repeat (4) send_pkt(mk_upd(4'd0, 16'hFFF0, 0, '1), 0);
    send_pkt(mk_upd(4'd0, 16'hFFFC, 70, 64'h0), 2);
    p = mk_upd(4'd0, 16'h0004, 70, 64'hFFFF_0000_FFFF_0000);
    p.bits = 127;
    p.smax = 16'h0020;
    send_pkt(p, 0);
    p = mk_upd(4'd0, 16'h0001, 10, 64'h0);
    p.slow = 16'h0000;
    p.rmax = 16'h0000;
    send_pkt(p, 1);
    p = mk_upd(4'd0, 16'h0010, 5, 64'h0);
    p.slow = 16'h0011;
    send_pkt(p, 0);
  endtask

  task automatic test_random(int n);
    int gap_mode;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) gap_mode = $urandom_range(0, 2);
      send_pkt(rand_pkt(), gap_mode == 0 ? 0 : $urandom_range(0, 5));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_membership();
    test_rtt();
    test_window();
    test_random(450);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

[multicast_ack_window_tracker_top.f]
rtl/mawt_pkg.sv
rtl/mawt_front.sv
rtl/mawt_div.sv
rtl/mawt_back.sv
rtl/multicast_ack_window_tracker_top.sv
verif/tb_top.sv
